// File: hw/rtl/cdhr_pkg.sv
// Package for the CD controller host register block.
// Holds function codes, port codes and FIFO depth defaults; no dependencies.
package cdhr_pkg;

  localparam int unsigned RespDepthDef  = 16;
  localparam int unsigned ParamDepthDef = 64;
  localparam int unsigned DataDepthDef  = 4096;

  typedef enum logic [2:0] {
    FUNC_CPU_READ   = 3'd0,
    FUNC_CPU_WRITE  = 3'd1,
    FUNC_PUSH_RESP  = 3'd2,
    FUNC_POP_PARAM  = 3'd3,
    FUNC_RAISE_IRQ  = 3'd4,
    FUNC_PUSH_DATA  = 3'd5,
    FUNC_SET_BUSY   = 3'd6,
    FUNC_CLEAR_RESP = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    PORT_0 = 2'd0,
    PORT_1 = 2'd1,
    PORT_2 = 2'd2,
    PORT_3 = 2'd3
  } port_e;

  localparam logic [7:0] ReqWantBit   = 8'h80;
  localparam logic [7:0] AckParamClr  = 8'h40;
  localparam logic [7:0] ApplyVolBit  = 8'h20;

  typedef struct packed {
    logic [2:0] func;
    logic [1:0] port;
    logic [7:0] wdata;
  } in_item_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       command_valid;
    logic [7:0] command_byte;
    logic       irq_request;
    logic       sector_wanted;
    logic       muted;
    logic [7:0] vol_left_left;
    logic [7:0] vol_left_right;
    logic [7:0] vol_right_left;
    logic [7:0] vol_right_right;
    logic [7:0] xa_coding;
  } out_item_t;

endpackage

// File: hw/rtl/cdhr_if.sv
// Valid/ready channel interfaces for the CD host register block.
// Depends on cdhr_pkg.
interface cdhr_in_if;
  logic               valid;
  logic               ready;
  cdhr_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface cdhr_out_if;
  logic                valid;
  logic                ready;
  cdhr_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/cd_controller_host_registers.sv
// Host side of a CD drive controller: banked ports, three FIFOs, irq and volume registers.
// Depends on cdhr_pkg and the channel interfaces in cdhr_if.sv.
//
//  channel  dir  payload
//  in_i     in   func, port, wdata
//  out_o    out  rdata, command_valid, command_byte, irq/want/mute, volumes, xa_coding
//
// One item per cycle. Stage one updates registers and FIFO pointers and issues the
// single FIFO memory access; stage two holds the registered memory read and drives the
// output register. A stalled output holds stage two and stops intake; no clearing pass,
// the FIFO stores are bounded by their pointers. Reset clears all control state.
module cd_controller_host_registers #(
  parameter int unsigned RESP_DEPTH  = cdhr_pkg::RespDepthDef,
  parameter int unsigned PARAM_DEPTH = cdhr_pkg::ParamDepthDef,
  parameter int unsigned DATA_DEPTH  = cdhr_pkg::DataDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  cdhr_in_if.sink    in_i,
  cdhr_out_if.source out_o
);
  localparam int RW = $clog2(RESP_DEPTH);
  localparam int PW = $clog2(PARAM_DEPTH);
  localparam int DW = $clog2(DATA_DEPTH);
  localparam int CW = $clog2(RESP_DEPTH + PARAM_DEPTH);

  // The response FIFO sits at the bottom of ctl_mem and the parameter FIFO above it.
  logic [7:0] ctl_mem   [RESP_DEPTH + PARAM_DEPTH];
  logic [7:0] data_mem  [DATA_DEPTH];

  logic [RW:0] resp_rd_q, resp_wr_q, resp_rd_d, resp_wr_d;
  logic [PW:0] prm_rd_q, prm_wr_q, prm_rd_d, prm_wr_d;
  logic [DW:0] dat_rd_q, dat_wr_d, dat_rd_d, dat_wr_q;

  logic [1:0] bank_q, bank_d;
  logic       busy_q, busy_d, want_q, want_d, mute_q, mute_d;
  logic [7:0] ien_q, ien_d, iflg_q, iflg_d, req_q, req_d, coding_q, coding_d;
  logic [7:0] pend_q [4];
  logic [7:0] pend_d [4];
  logic [7:0] appl_q [4];
  logic [7:0] appl_d [4];

  logic       out_valid_q;
  logic [1:0] sel_q, sel_d;   // 0 direct, 1 resp, 2 param, 3 data
  logic [7:0] direct_q, direct_d, rd_ctl_q, rd_dat_q;
  logic       cv_q, cv_d;
  logic [7:0] cb_q, cb_d;

  logic accept, stage_free;
  logic resp_is_empty, resp_full, prm_empty, prm_full, dat_empty, dat_full;
  logic resp_we, prm_we, dat_we, resp_re, prm_re, dat_re;
  logic ctl_we, ctl_re;
  logic [CW-1:0] ctl_wa, ctl_ra;
  cdhr_pkg::func_e func;
  cdhr_pkg::port_e port;
  logic [7:0] wd;

  assign stage_free = !out_valid_q || out_o.ready;
  assign in_i.ready = stage_free;
  assign accept     = in_i.valid && stage_free;
  assign func = cdhr_pkg::func_e'(in_i.payload.func);
  assign port = cdhr_pkg::port_e'(in_i.payload.port);
  assign wd   = in_i.payload.wdata;

  assign resp_is_empty = resp_rd_q == resp_wr_q;
  assign resp_full  = (resp_rd_q[RW-1:0] == resp_wr_q[RW-1:0]) && !resp_is_empty;
  assign prm_empty  = prm_rd_q == prm_wr_q;
  assign prm_full   = (prm_rd_q[PW-1:0] == prm_wr_q[PW-1:0]) && !prm_empty;
  assign dat_empty  = dat_rd_q == dat_wr_q;
  assign dat_full   = (dat_rd_q[DW-1:0] == dat_wr_q[DW-1:0]) && !dat_empty;

  always_comb begin
    bank_d = bank_q; busy_d = busy_q; want_d = want_q; mute_d = mute_q;
    ien_d = ien_q; iflg_d = iflg_q; req_d = req_q; coding_d = coding_q;
    pend_d = pend_q; appl_d = appl_q;
    resp_rd_d = resp_rd_q; resp_wr_d = resp_wr_q;
    prm_rd_d = prm_rd_q; prm_wr_d = prm_wr_q;
    dat_rd_d = dat_rd_q; dat_wr_d = dat_wr_q;
    resp_we = 1'b0; prm_we = 1'b0; dat_we = 1'b0;
    resp_re = 1'b0; prm_re = 1'b0; dat_re = 1'b0;
    sel_d = 2'd0; direct_d = 8'h00; cv_d = 1'b0; cb_d = 8'h00;
    if (accept) begin
      case (func)
        cdhr_pkg::FUNC_CPU_READ: begin
          case (port)
            cdhr_pkg::PORT_0: direct_d = {busy_q, !dat_empty, !resp_is_empty, !prm_full,
                                          prm_empty, 1'b0, bank_q};
            cdhr_pkg::PORT_1: if (!resp_is_empty) begin
              resp_re = 1'b1; sel_d = 2'd1; resp_rd_d = resp_rd_q + 1'b1;
            end
            cdhr_pkg::PORT_2: if (!dat_empty) begin
              dat_re = 1'b1; sel_d = 2'd3; dat_rd_d = dat_rd_q + 1'b1;
            end
            default: direct_d = bank_q[0] ? iflg_q : ien_q;
          endcase
        end
        cdhr_pkg::FUNC_CPU_WRITE: begin
          case (port)
            cdhr_pkg::PORT_0: bank_d = wd[1:0];
            cdhr_pkg::PORT_1: begin
              case (bank_q)
                2'd0: begin cv_d = 1'b1; cb_d = wd; busy_d = 1'b1; end
                2'd2: coding_d = wd;
                2'd3: pend_d[3] = wd;
                default: ;
              endcase
            end
            cdhr_pkg::PORT_2: begin
              case (bank_q)
                2'd0: if (!prm_full) begin prm_we = 1'b1; prm_wr_d = prm_wr_q + 1'b1; end
                2'd1: ien_d = wd;
                2'd2: pend_d[0] = wd;
                default: pend_d[2] = wd;
              endcase
            end
            default: begin
              case (bank_q)
                2'd0: begin
                  if (!req_q[7] && wd[7]) want_d = 1'b1;
                  req_d = wd;
                  if ((wd & cdhr_pkg::ReqWantBit) == 8'h00) begin
                    dat_rd_d = '0; dat_wr_d = '0; want_d = 1'b0;
                  end
                end
                2'd1: begin
                  iflg_d = iflg_q & ~wd;
                  if ((wd & cdhr_pkg::AckParamClr) != 8'h00) begin
                    prm_rd_d = '0; prm_wr_d = '0;
                  end
                end
                2'd2: pend_d[1] = wd;
                default: begin
                  mute_d = wd[0];
                  if ((wd & cdhr_pkg::ApplyVolBit) != 8'h00) appl_d = pend_q;
                end
              endcase
            end
          endcase
        end
        cdhr_pkg::FUNC_PUSH_RESP: if (!resp_full) begin
          resp_we = 1'b1; resp_wr_d = resp_wr_q + 1'b1;
        end
        cdhr_pkg::FUNC_POP_PARAM: if (!prm_empty) begin
          prm_re = 1'b1; sel_d = 2'd2; prm_rd_d = prm_rd_q + 1'b1;
        end
        cdhr_pkg::FUNC_RAISE_IRQ: iflg_d = iflg_q | wd;
        cdhr_pkg::FUNC_PUSH_DATA: if (!dat_full) begin
          dat_we = 1'b1; dat_wr_d = dat_wr_q + 1'b1;
        end
        cdhr_pkg::FUNC_SET_BUSY: busy_d = wd[0];
        default: begin resp_rd_d = '0; resp_wr_d = '0; end
      endcase
    end
  end

  // A beat touches at most one of the two small FIFOs, so they share one port pair.
  assign ctl_we = resp_we || prm_we;
  assign ctl_re = resp_re || prm_re;
  assign ctl_wa = resp_we ? CW'(resp_wr_q[RW-1:0]) : CW'(RESP_DEPTH + prm_wr_q[PW-1:0]);
  assign ctl_ra = resp_re ? CW'(resp_rd_q[RW-1:0]) : CW'(RESP_DEPTH + prm_rd_q[PW-1:0]);

  // A write and a read never hit the same entry: reads only see entries already pushed.
  always_ff @(posedge clk_i) begin
    if (ctl_we) ctl_mem[ctl_wa] <= wd;
    if (ctl_re) rd_ctl_q <= ctl_mem[ctl_ra];
  end
  always_ff @(posedge clk_i) begin
    if (dat_we) data_mem[dat_wr_q[DW-1:0]] <= wd;
    if (dat_re) rd_dat_q <= data_mem[dat_rd_q[DW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= '0; busy_q <= 1'b0; want_q <= 1'b0; mute_q <= 1'b0;
      ien_q <= '0; iflg_q <= '0; req_q <= '0; coding_q <= '0;
      for (int i = 0; i < 4; i++) begin pend_q[i] <= '0; appl_q[i] <= '0; end
      resp_rd_q <= '0; resp_wr_q <= '0; prm_rd_q <= '0; prm_wr_q <= '0;
      dat_rd_q <= '0; dat_wr_q <= '0;
      out_valid_q <= 1'b0; sel_q <= '0; direct_q <= '0; cv_q <= 1'b0; cb_q <= '0;
    end else begin
      bank_q <= bank_d; busy_q <= busy_d; want_q <= want_d; mute_q <= mute_d;
      ien_q <= ien_d; iflg_q <= iflg_d; req_q <= req_d; coding_q <= coding_d;
      pend_q <= pend_d; appl_q <= appl_d;
      resp_rd_q <= resp_rd_d; resp_wr_q <= resp_wr_d;
      prm_rd_q <= prm_rd_d; prm_wr_q <= prm_wr_d;
      dat_rd_q <= dat_rd_d; dat_wr_q <= dat_wr_d;
      if (stage_free) begin
        out_valid_q <= in_i.valid;
        sel_q <= sel_d; direct_q <= direct_d; cv_q <= cv_d; cb_q <= cb_d;
      end
    end
  end

  // Status outputs come straight from the state registers after the beat, not from the output stage.
  always_comb begin
    out_o.valid = out_valid_q;
    case (sel_q)
      2'd1:    out_o.payload.rdata = rd_ctl_q;
      2'd2:    out_o.payload.rdata = rd_ctl_q;
      2'd3:    out_o.payload.rdata = rd_dat_q;
      default: out_o.payload.rdata = direct_q;
    endcase
    out_o.payload.command_valid   = cv_q;
    out_o.payload.command_byte    = cb_q;
    out_o.payload.irq_request     = (iflg_q & ien_q) != 8'h00;
    out_o.payload.sector_wanted   = want_q;
    out_o.payload.muted           = mute_q;
    out_o.payload.vol_left_left   = appl_q[0];
    out_o.payload.vol_left_right  = appl_q[1];
    out_o.payload.vol_right_left  = appl_q[2];
    out_o.payload.vol_right_right = appl_q[3];
    out_o.payload.xa_coding       = coding_q;
  end
endmodule

// File: hw/rtl/cdhr_checker.sv
// Port-level checker for the CD host register block, bound to the top level.
// Depends on cdhr_pkg and the channel interfaces.
module cdhr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input cdhr_pkg::out_item_t out_payload
);
  // Every accepted beat yields a result beat in the next cycle.
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> out_valid) else $error("missing result");
  // A pending unconsumed result blocks intake.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready) else $error("intake while stalled");
  a_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_payload.command_valid |-> out_payload.command_byte == 8'h00)
    else $error("stray command byte");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result changed under stall");
endmodule

bind cd_controller_host_registers cdhr_checker u_cdhr_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_i.valid), .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready), .out_payload(out_o.payload)
);
